>>> src/binary_heap_priority_queue_macros.svh
// Assertion helpers for the heap queue checker.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BHPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bhpq: assertion failed");

// Next-cycle implication.
`define BHPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bhpq: assertion failed");

`endif

>>> src/bhpq_pkg.sv
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;

  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned CHILD_W = ADDR_W + 2;
  localparam int unsigned ENTRY_W = KEY_BITS + TAG_BITS;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PU_CMP,
    S_PO_ROOT,
    S_PO_CMP,
    S_WR,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic                hit;
    status_e             status;
    logic [CNT_W-1:0]    occ;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  // a precedes b in the selected order
  function automatic logic precedes(input logic max_first,
                                    input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
    return max_first ? (a > b) : (a < b);
  endfunction

endpackage

>>> src/bhpq_ram.sv
`timescale 1ns / 1ps

module bhpq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> src/bhpq_sift.sv
`timescale 1ns / 1ps

module bhpq_sift (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           max_first_i,
  input  logic                           cmd_valid_i,
  output logic                           cmd_stall_o,
  input  logic                           cmd_i,
  input  logic [bhpq_pkg::KEY_BITS-1:0]  key_i,
  input  logic [bhpq_pkg::TAG_BITS-1:0]  tag_i,
  input  bhpq_pkg::entry_t               rd_a_i,
  input  bhpq_pkg::entry_t               rd_b_i,
  output bhpq_pkg::ram_req_t             ram_o,
  output logic                           res_vld_o,
  input  logic                           res_rdy_i,
  output bhpq_pkg::res_t                 res_o
);

  bhpq_pkg::state_e state_q, state_d;
  logic [bhpq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [bhpq_pkg::ADDR_W-1:0] idx_q, idx_d;
  bhpq_pkg::entry_t            cur_q, cur_d;
  bhpq_pkg::res_t              res_q, res_d;

  logic                          is_full, is_empty;
  logic [bhpq_pkg::ADDR_W-1:0]   idx_m1, par_idx, par_m1, push_par, last_idx;
  logic [bhpq_pkg::CNT_W-1:0]    cnt_m1;
  logic [bhpq_pkg::CHILD_W-1:0]  left, right, cnt_ext, pick_c, nleft;
  logic [bhpq_pkg::ADDR_W-1:0]   pick_idx;
  logic                          has_right, pick_r, go_up, go_down, more_down;
  bhpq_pkg::entry_t              child, new_ent;

  assign is_full  = count_q == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY);
  assign is_empty = count_q == '0;
  assign cnt_m1   = count_q - bhpq_pkg::CNT_W'(1);
  assign push_par = bhpq_pkg::ADDR_W'(cnt_m1 >> 1);
  assign last_idx = bhpq_pkg::ADDR_W'(cnt_m1);
  assign idx_m1   = idx_q - bhpq_pkg::ADDR_W'(1);
  assign par_idx  = idx_m1 >> 1;
  assign par_m1   = par_idx - bhpq_pkg::ADDR_W'(1);
  assign new_ent  = '{key: key_i, tag: tag_i};

  assign left      = {1'b0, idx_q, 1'b1};
  assign right     = left + bhpq_pkg::CHILD_W'(1);
  assign cnt_ext   = bhpq_pkg::CHILD_W'(count_q);
  assign has_right = right < cnt_ext;
  // ties go right
  assign pick_r    = has_right && !bhpq_pkg::precedes(max_first_i, rd_a_i.key, rd_b_i.key);
  assign child     = pick_r ? rd_b_i : rd_a_i;
  assign pick_c    = pick_r ? right : left;
  assign pick_idx  = bhpq_pkg::ADDR_W'(pick_c);
  assign nleft     = {1'b0, pick_idx, 1'b1};
  assign more_down = nleft < cnt_ext;

  assign go_up   = bhpq_pkg::precedes(max_first_i, cur_q.key, rd_a_i.key);
  assign go_down = bhpq_pkg::precedes(max_first_i, child.key, cur_q.key);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bhpq_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i == bhpq_pkg::CMD_PUSH) begin
            state_d = (is_full || is_empty) ? bhpq_pkg::S_FIN : bhpq_pkg::S_PU_CMP;
          end else begin
            state_d = is_empty ? bhpq_pkg::S_FIN : bhpq_pkg::S_PO_ROOT;
          end
        end
      end
      bhpq_pkg::S_PU_CMP: begin
        if (go_up) begin
          state_d = (par_idx == '0) ? bhpq_pkg::S_WR : bhpq_pkg::S_PU_CMP;
        end else begin
          state_d = bhpq_pkg::S_FIN;
        end
      end
      bhpq_pkg::S_PO_ROOT: begin
        state_d = (count_q > bhpq_pkg::CNT_W'(1)) ? bhpq_pkg::S_PO_CMP : bhpq_pkg::S_FIN;
      end
      bhpq_pkg::S_PO_CMP: begin
        if (go_down) begin
          state_d = more_down ? bhpq_pkg::S_PO_CMP : bhpq_pkg::S_WR;
        end else begin
          state_d = bhpq_pkg::S_FIN;
        end
      end
      bhpq_pkg::S_WR: begin
        state_d = bhpq_pkg::S_FIN;
      end
      bhpq_pkg::S_FIN: begin
        if (res_rdy_i) begin
          state_d = bhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bhpq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_o   = '0;
    count_d = count_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    res_d   = res_q;
    case (state_q)
      bhpq_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          res_d = '0;
          if (cmd_i == bhpq_pkg::CMD_PUSH) begin
            if (is_full) begin
              res_d.status = bhpq_pkg::STAT_FULL;
              res_d.occ    = count_q;
            end else begin
              count_d   = count_q + bhpq_pkg::CNT_W'(1);
              res_d.occ = count_q + bhpq_pkg::CNT_W'(1);
              cur_d     = new_ent;
              idx_d     = bhpq_pkg::ADDR_W'(count_q);
              if (is_empty) begin
                ram_o.we    = 1'b1;
                ram_o.wdata = new_ent;
              end else begin
                ram_o.raddr_a = push_par;
              end
            end
          end else begin
            if (is_empty) begin
              res_d.status = bhpq_pkg::STAT_EMPTY;
            end else begin
              count_d       = cnt_m1;
              res_d.occ     = cnt_m1;
              idx_d         = '0;
              ram_o.raddr_b = last_idx;
            end
          end
        end
      end
      bhpq_pkg::S_PU_CMP: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        if (go_up) begin
          ram_o.wdata   = rd_a_i;
          idx_d         = par_idx;
          ram_o.raddr_a = par_m1 >> 1;
        end else begin
          ram_o.wdata = cur_q;
        end
      end
      bhpq_pkg::S_PO_ROOT: begin
        res_d.key = rd_a_i.key;
        res_d.tag = rd_a_i.tag;
        res_d.hit = 1'b1;
        cur_d     = rd_b_i;
        if (count_q == bhpq_pkg::CNT_W'(1)) begin
          ram_o.we    = 1'b1;
          ram_o.wdata = rd_b_i;
        end
        ram_o.raddr_a = bhpq_pkg::ADDR_W'(1);
        ram_o.raddr_b = bhpq_pkg::ADDR_W'(2);
      end
      bhpq_pkg::S_PO_CMP: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        if (go_down) begin
          ram_o.wdata   = child;
          idx_d         = pick_idx;
          ram_o.raddr_a = bhpq_pkg::ADDR_W'(nleft);
          ram_o.raddr_b = bhpq_pkg::ADDR_W'(nleft + bhpq_pkg::CHILD_W'(1));
        end else begin
          ram_o.wdata = cur_q;
        end
      end
      bhpq_pkg::S_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        ram_o.wdata = cur_q;
      end
      default: begin
      end
    endcase
  end

  assign cmd_stall_o = state_q != bhpq_pkg::S_IDLE;
  assign res_vld_o   = state_q == bhpq_pkg::S_FIN;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhpq_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    res_q <= res_d;
  end

endmodule

>>> src/bhpq_out.sv
`timescale 1ns / 1ps

module bhpq_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_vld_i,
  output logic           in_rdy_o,
  input  bhpq_pkg::res_t in_res_i,
  output logic           out_vld_o,
  input  logic           out_stall_i,
  output bhpq_pkg::res_t out_res_o
);

  logic           vld_q, vld_d;
  bhpq_pkg::res_t res_q, res_d;

  assign in_rdy_o = !vld_q || !out_stall_i;
  assign vld_d    = in_rdy_o ? in_vld_i : vld_q;
  assign res_d    = (in_rdy_o && in_vld_i) ? in_res_i : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_vld_o = vld_q;
  assign out_res_o = res_q;

endmodule

>>> src/binary_heap_priority_queue.sv
`timescale 1ns / 1ps

// Binary heap priority queue of (key, tag) entries, up to 256 held in one
// 256 x 48 memory with two registered read ports; max_first picks pop order
// (0 smallest key first, 1 largest). One command at a time: a push into an
// empty heap writes the root directly, otherwise the new entry climbs toward
// the root one tree level per compare step; a pop takes the root and sifts the
// last entry down level by level, each step paced by the registered memory
// reads; the result then passes to the output register. That register lets
// the next command in while a result still waits. The memory needs no clearing
// after reset: data read from slots at or above the count is never used. A full
// push reports status 2, an empty pop status 1; both leave the heap as it was.
module binary_heap_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_stall_o,
  input  logic                          cmd_i,
  input  logic [bhpq_pkg::KEY_BITS-1:0] key_i,
  input  logic [bhpq_pkg::TAG_BITS-1:0] tag_i,
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic [bhpq_pkg::KEY_BITS-1:0] out_key_o,
  output logic [bhpq_pkg::TAG_BITS-1:0] out_tag_o,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [bhpq_pkg::CNT_W-1:0]    occupancy_o
);

  logic               max_first_q, max_first_d;
  bhpq_pkg::ram_req_t ram_req;
  bhpq_pkg::entry_t   rd_a, rd_b;
  logic               res_vld, res_rdy;
  bhpq_pkg::res_t     res, res_out;

  assign max_first_d = cfg_we_i ? cfg_wdata_i : max_first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_first_q <= 1'b0;
    end else begin
      max_first_q <= max_first_d;
    end
  end

  bhpq_ram #(
    .DEPTH (bhpq_pkg::CAPACITY),
    .WIDTH (bhpq_pkg::ENTRY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr),
    .wdata_i   (ram_req.wdata),
    .raddr_a_i (ram_req.raddr_a),
    .raddr_b_i (ram_req.raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  bhpq_sift u_sift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_first_i (max_first_q),
    .cmd_valid_i (cmd_valid_i),
    .cmd_stall_o (cmd_stall_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .tag_i       (tag_i),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .ram_o       (ram_req),
    .res_vld_o   (res_vld),
    .res_rdy_i   (res_rdy),
    .res_o       (res)
  );

  bhpq_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (res_vld),
    .in_rdy_o    (res_rdy),
    .in_res_i    (res),
    .out_vld_o   (res_valid_o),
    .out_stall_i (res_stall_i),
    .out_res_o   (res_out)
  );

  assign out_key_o   = res_out.key;
  assign out_tag_o   = res_out.tag;
  assign out_valid_o = res_out.hit;
  assign status_o    = res_out.status;
  assign occupancy_o = res_out.occ;

endmodule

>>> src/bhpq_chk.sv
`timescale 1ns / 1ps

`include "binary_heap_priority_queue_macros.svh"

module bhpq_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          cfg_wdata_i,
  input logic                          cmd_valid_i,
  input logic                          cmd_stall_o,
  input logic                          cmd_i,
  input logic [bhpq_pkg::KEY_BITS-1:0] key_i,
  input logic [bhpq_pkg::TAG_BITS-1:0] tag_i,
  input logic                          res_valid_o,
  input logic                          res_stall_i,
  input logic [bhpq_pkg::KEY_BITS-1:0] out_key_o,
  input logic [bhpq_pkg::TAG_BITS-1:0] out_tag_o,
  input logic                          out_valid_o,
  input logic [1:0]                    status_o,
  input logic [bhpq_pkg::CNT_W-1:0]    occupancy_o
);

  // one command in flight
  `BHPQ_ASSERT_NEXT(a_one_cmd, cmd_valid_i && !cmd_stall_o, cmd_stall_o)

  // a refused command returns no entry
  `BHPQ_ASSERT_NOW(a_fail_no_entry, res_valid_o && (status_o != bhpq_pkg::STAT_OK), !out_valid_o && (out_key_o == '0) && (out_tag_o == '0))

  `BHPQ_ASSERT_NOW(a_full_occ, res_valid_o && (status_o == bhpq_pkg::STAT_FULL), occupancy_o == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))

  `BHPQ_ASSERT_NOW(a_empty_occ, res_valid_o && (status_o == bhpq_pkg::STAT_EMPTY), occupancy_o == '0)

  `BHPQ_ASSERT_NEXT(a_res_hold, res_valid_o && res_stall_i, res_valid_o && $stable(out_key_o) && $stable(status_o) && $stable(occupancy_o))

endmodule

bind binary_heap_priority_queue bhpq_chk u_chk (.*);

>>> tb/binary_heap_priority_queue_test.sv
`timescale 1ns / 1ps

module binary_heap_priority_queue_test;
  import bhpq_pkg::*;

  typedef struct packed {
    logic                cmd;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } heap_cmd_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                cmd_valid_i = 1'b0;
  logic                cmd_stall_o;
  logic                cmd_i       = CMD_PUSH;
  logic [KEY_BITS-1:0] key_i       = '0;
  logic [TAG_BITS-1:0] tag_i       = '0;
  logic                res_valid_o;
  logic                res_stall_i = 1'b0;
  logic [KEY_BITS-1:0] out_key_o;
  logic [TAG_BITS-1:0] out_tag_o;
  logic                out_valid_o;
  logic [1:0]          status_o;
  logic [CNT_W-1:0]    occupancy_o;

  binary_heap_priority_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid_i),
    .cmd_stall_o (cmd_stall_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .tag_i       (tag_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_key_o   (out_key_o),
    .out_tag_o   (out_tag_o),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // shadow heap
  logic [KEY_BITS-1:0] shadow_key [CAPACITY];
  logic [TAG_BITS-1:0] shadow_tag [CAPACITY];
  int                  shadow_count = 0;
  logic                shadow_max_first = 1'b0;

  heap_cmd_t queued_cmds [$];
  res_t      pending_results [$];
  res_t      want;
  int        gen_held = 0;
  int        errors = 0;
  bit        beat_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        stall_mode = 0;
  int        mode_left = 0;
  int        n_results = 0;
  int        n_popped = 0;
  int        n_empty = 0;
  int        n_dropped = 0;
  int        peak_occ = 0;

  function automatic bit key_first(input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b);
    return shadow_max_first ? (a > b) : (a < b);
  endfunction

  task automatic swap_slots(input int a, input int b);
    logic [KEY_BITS-1:0] tk;
    logic [TAG_BITS-1:0] tt;
    tk = shadow_key[a];
    tt = shadow_tag[a];
    shadow_key[a] = shadow_key[b];
    shadow_tag[a] = shadow_tag[b];
    shadow_key[b] = tk;
    shadow_tag[b] = tt;
  endtask

  task automatic apply_heap_cmd(input logic cmd, input logic [KEY_BITS-1:0] key,
                                input logic [TAG_BITS-1:0] tag);
    res_t r;
    int   idx;
    int   up;
    int   lt;
    int   pick;
    r = '0;
    r.status = STAT_OK;
    if (cmd == CMD_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        idx = shadow_count;
        shadow_key[idx] = key;
        shadow_tag[idx] = tag;
        shadow_count++;
        while (idx > 0) begin
          up = (idx - 1) / 2;
          if (!key_first(shadow_key[idx], shadow_key[up])) break;
          swap_slots(idx, up);
          idx = up;
        end
      end
    end else if (shadow_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.key = shadow_key[0];
      r.tag = shadow_tag[0];
      r.hit = 1'b1;
      shadow_count--;
      shadow_key[0] = shadow_key[shadow_count];
      shadow_tag[0] = shadow_tag[shadow_count];
      idx = 0;
      while (2 * idx + 1 < shadow_count) begin
        lt = 2 * idx + 1;
        pick = lt;
        // ties go right
        if (lt + 1 < shadow_count && !key_first(shadow_key[lt], shadow_key[lt + 1]))
          pick = lt + 1;
        if (!key_first(shadow_key[pick], shadow_key[idx])) break;
        swap_slots(idx, pick);
        idx = pick;
      end
    end
    r.occ = CNT_W'(shadow_count);
    pending_results.push_back(r);
  endtask

  // accept side: predict from what was actually driven
  always @(posedge clk_i) begin
    if (rst_ni && cmd_valid_i && !cmd_stall_o) begin
      apply_heap_cmd(cmd_i, key_i, tag_i);
      void'(queued_cmds.pop_front());
      beat_taken = 1'b1;
    end
  end

  // driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_valid_i <= 1'b0;
    end else if (!(cmd_valid_i && !beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid_i <= 1'b0;
      end else if (queued_cmds.size() > 0) begin
        cmd_valid_i <= 1'b1;
        cmd_i       <= queued_cmds[0].cmd;
        key_i       <= queued_cmds[0].key;
        tag_i       <= queued_cmds[0].tag;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        cmd_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      res_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: res_stall_i <= 1'b0;
        1: res_stall_i <= ($urandom_range(0, 3) == 0);
        default: res_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual key %0h tag %0h status %0d",
                 $time, out_key_o, out_tag_o, status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_key", want.key, out_key_o);
        check_field("out_tag", want.tag, out_tag_o);
        check_field("out_valid", want.hit, out_valid_o);
        check_field("status", want.status, status_o);
        check_field("occupancy", want.occ, occupancy_o);
        if (want.hit) n_popped++;
        if (want.status == STAT_EMPTY) n_empty++;
        if (want.status == STAT_FULL) n_dropped++;
        if (want.occ > peak_occ) peak_occ = want.occ;
      end
    end
  end

  task automatic queue_cmd(input logic cmd, input logic [KEY_BITS-1:0] key,
                           input logic [TAG_BITS-1:0] tag);
    heap_cmd_t c;
    c.cmd = cmd;
    c.key = key;
    c.tag = tag;
    queued_cmds.push_back(c);
    if (cmd == CMD_PUSH && gen_held < CAPACITY) gen_held++;
    if (cmd == CMD_POP && gen_held > 0) gen_held--;
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom;
    if (sel < 9) return $urandom_range(0, 15);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 1;
      default: return {{(KEY_BITS-1){1'b1}}, 1'b0};
    endcase
  endfunction

  task automatic queue_random(input logic cmd);
    queue_cmd(cmd, pick_key(), TAG_BITS'($urandom));
  endtask

  task automatic wait_idle();
    while (queued_cmds.size() != 0 || pending_results.size() != 0 || cmd_valid_i)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_order(input logic max_first);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= max_first;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_max_first = max_first;
  endtask

  task automatic fill_and_drain();
    int n;
    while (gen_held < CAPACITY) queue_random(CMD_PUSH);
    repeat (3) queue_random(CMD_PUSH);
    n = gen_held + 3;
    repeat (n) queue_random(CMD_POP);
  endtask

  task automatic mix_phase(input int n, input int push_pct);
    repeat (n) queue_random(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP);
  endtask

  initial begin
    #2_000_000;
    $display("binary_heap_priority_queue_test: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    set_order(1'b0);
    queue_cmd(CMD_POP, '0, '0);
    queue_cmd(CMD_PUSH, 32'h0000_0000, 16'h0000);
    queue_cmd(CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    queue_cmd(CMD_PUSH, 32'h5555_5555, 16'hAAAA);
    queue_cmd(CMD_PUSH, 32'hAAAA_AAAA, 16'h5555);
    // equal keys: tag order shows the tie rule
    queue_cmd(CMD_PUSH, 32'd7, 16'd1);
    queue_cmd(CMD_PUSH, 32'd7, 16'd2);
    queue_cmd(CMD_PUSH, 32'd7, 16'd3);
    repeat (8) queue_cmd(CMD_POP, '1, '1);
    wait_idle();

    set_order(1'b1);
    queue_cmd(CMD_PUSH, 32'h0000_0000, 16'h0101);
    queue_cmd(CMD_PUSH, 32'hFFFF_FFFF, 16'h0202);
    queue_cmd(CMD_PUSH, 32'd9, 16'd4);
    queue_cmd(CMD_PUSH, 32'd9, 16'd5);
    repeat (4) queue_cmd(CMD_POP, '0, '0);
    wait_idle();

    set_order(1'b0);
    fill_and_drain();
    wait_idle();

    set_order(1'b1);
    fill_and_drain();
    wait_idle();

    set_order(1'b0);
    hold_req = 1'b1;
    mix_phase(200, 60);
    wait_idle();

    // order flips with entries still held
    set_order(1'b1);
    mix_phase(200, 50);
    wait_idle();

    set_order(1'b0);
    mix_phase(200, 40);
    wait_idle();

    set_order(1'b1);
    mix_phase(200, 55);
    wait_idle();

    $display("checked %0d result beats: %0d entries popped, %0d empty pops, %0d full drops",
             n_results, n_popped, n_empty, n_dropped);
    $display("peak occupancy %0d, both pop orders, order flips on a nonempty heap, long hold-off",
             peak_occ);
    if (errors == 0) begin
      $display("binary_heap_priority_queue_test: PASS");
    end else begin
      $display("binary_heap_priority_queue_test: FAIL");
    end
    $finish;
  end

endmodule
